// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset.
`define BWS_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) prop) \
        else $error("assertion failed");

// Checked at every edge, reset included.
`define BWS_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) else $error("assertion failed");

`endif

// ===== rtl/bws_pkg.sv =====
package bws_pkg;

    localparam int NUM_LANES = 8;

    localparam int PROX_W   = 12;
    localparam int WEIGHT_W = 13;
    localparam int TERM_W   = 13;
    localparam int OFFSET_W = 13;
    localparam int LIMIT_W  = 15;
    localparam int SPEED_W  = 16;
    localparam int SUM_W    = 17;
    localparam int SLEW_W   = 18;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_LEFT     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_RIGHT    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED_LIMIT     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_STEP_CHANGE = 2'd3;

    localparam logic signed [OFFSET_W-1:0] OFFSET_RESET = 13'sd640;
    localparam logic [LIMIT_W-1:0]         LIMIT_RESET  = 15'd2560;
    localparam logic [LIMIT_W-1:0]         STEP_RESET   = 15'd25;

    // Weights scaled by 2560 (top speed times 256)
    localparam logic signed [WEIGHT_W-1:0] W_LEFT [NUM_LANES] = '{
        -13'sd3328, -13'sd3328, -13'sd1280, 13'sd0,
        13'sd0, 13'sd128, -13'sd1920, -13'sd1920
    };
    localparam logic signed [WEIGHT_W-1:0] W_RIGHT [NUM_LANES] = '{
        -13'sd2560, -13'sd2560, 13'sd1280, 13'sd0,
        13'sd0, -13'sd1280, 13'sd0, 13'sd0
    };

    typedef struct packed {
        logic [PROX_W-1:0] prox_0;
        logic [PROX_W-1:0] prox_1;
        logic [PROX_W-1:0] prox_2;
        logic [PROX_W-1:0] prox_3;
        logic [PROX_W-1:0] prox_4;
        logic [PROX_W-1:0] prox_5;
        logic [PROX_W-1:0] prox_6;
        logic [PROX_W-1:0] prox_7;
    } t_bws_in;

    typedef struct packed {
        logic signed [SPEED_W-1:0] left_speed;
        logic signed [SPEED_W-1:0] right_speed;
    } t_bws_out;

endpackage

// ===== rtl/bws_lane.sv =====
module bws_lane
    import bws_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_en,
    input  logic [PROX_W-1:0]          i_prox,
    input  logic signed [WEIGHT_W-1:0] i_wl,
    input  logic signed [WEIGHT_W-1:0] i_wr,
    output logic signed [TERM_W-1:0]   o_left,
    output logic signed [TERM_W-1:0]   o_right
);

    logic signed [PROX_W+WEIGHT_W:0] w_pl;
    logic signed [PROX_W+WEIGHT_W:0] w_pr;
    logic signed [TERM_W-1:0]        r_left;
    logic signed [TERM_W-1:0]        r_right;

    assign w_pl = $signed({1'b0, i_prox}) * i_wl;
    assign w_pr = $signed({1'b0, i_prox}) * i_wr;

    // floor divide by 4096
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_left  <= w_pl[TERM_W+11:12];
            r_right <= w_pr[TERM_W+11:12];
        end
    end

    assign o_left  = r_left;
    assign o_right = r_right;

endmodule

// ===== rtl/bws_merge.sv =====
module bws_merge
    import bws_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  logic                       i_valid,
    input  logic signed [TERM_W-1:0]   i_left  [NUM_LANES],
    input  logic signed [TERM_W-1:0]   i_right [NUM_LANES],
    input  logic signed [OFFSET_W-1:0] i_offset_left,
    input  logic signed [OFFSET_W-1:0] i_offset_right,
    input  logic [LIMIT_W-1:0]         i_speed_limit,
    output logic                       o_valid,
    output logic signed [SPEED_W-1:0]  o_target_left,
    output logic signed [SPEED_W-1:0]  o_target_right
);

    logic signed [SUM_W-1:0]   n_sum_l;
    logic signed [SUM_W-1:0]   n_sum_r;
    logic signed [SUM_W-1:0]   r_sum_l;
    logic signed [SUM_W-1:0]   r_sum_r;
    logic                      r_v_sum;
    logic                      r_v_tgt;
    logic signed [SUM_W-1:0]   w_lim;
    logic signed [SPEED_W-1:0] n_tgt_l;
    logic signed [SPEED_W-1:0] n_tgt_r;
    logic signed [SPEED_W-1:0] r_tgt_l;
    logic signed [SPEED_W-1:0] r_tgt_r;

    always_comb begin
        n_sum_l = SUM_W'(i_offset_left);
        n_sum_r = SUM_W'(i_offset_right);
        for (int k = 0; k < NUM_LANES; k++) begin
            n_sum_l = n_sum_l + SUM_W'(i_left[k]);
            n_sum_r = n_sum_r + SUM_W'(i_right[k]);
        end
    end

    assign w_lim = $signed({2'b00, i_speed_limit});

    always_comb begin
        if (r_sum_l > w_lim) begin
            n_tgt_l = w_lim[SPEED_W-1:0];
        end else if (r_sum_l < -w_lim) begin
            n_tgt_l = SPEED_W'(-w_lim);
        end else begin
            n_tgt_l = r_sum_l[SPEED_W-1:0];
        end
        if (r_sum_r > w_lim) begin
            n_tgt_r = w_lim[SPEED_W-1:0];
        end else if (r_sum_r < -w_lim) begin
            n_tgt_r = SPEED_W'(-w_lim);
        end else begin
            n_tgt_r = r_sum_r[SPEED_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v_sum <= 1'b0;
            r_v_tgt <= 1'b0;
        end else if (i_en) begin
            r_v_sum <= i_valid;
            r_v_tgt <= r_v_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sum_l <= n_sum_l;
            r_sum_r <= n_sum_r;
            r_tgt_l <= n_tgt_l;
            r_tgt_r <= n_tgt_r;
        end
    end

    assign o_valid        = r_v_tgt;
    assign o_target_left  = r_tgt_l;
    assign o_target_right = r_tgt_r;

endmodule

// ===== rtl/bws_slew.sv =====
module bws_slew
    import bws_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_en,
    input  logic                      i_valid,
    input  logic signed [SPEED_W-1:0] i_target_left,
    input  logic signed [SPEED_W-1:0] i_target_right,
    input  logic [LIMIT_W-1:0]        i_max_step,
    input  logic                      i_out_ready,
    output logic                      o_out_valid,
    output t_bws_out                  o_out_data
);

    logic signed [SPEED_W-1:0] r_last_l;
    logic signed [SPEED_W-1:0] r_last_r;
    logic                      r_out_valid;
    logic signed [SPEED_W-1:0] n_last_l;
    logic signed [SPEED_W-1:0] n_last_r;

    function automatic logic signed [SPEED_W-1:0] slew_step(
        input logic signed [SPEED_W-1:0] tgt,
        input logic signed [SPEED_W-1:0] cur,
        input logic [LIMIT_W-1:0]        step
    );
        logic signed [SLEW_W-1:0] hi;
        logic signed [SLEW_W-1:0] lo;
        logic signed [SLEW_W-1:0] t;
        logic signed [SPEED_W-1:0] res;
        hi = SLEW_W'(cur) + $signed({3'b000, step});
        lo = SLEW_W'(cur) - $signed({3'b000, step});
        t  = SLEW_W'(tgt);
        if (t > hi) begin
            res = hi[SPEED_W-1:0];
        end else if (t < lo) begin
            res = lo[SPEED_W-1:0];
        end else begin
            res = tgt;
        end
        return res;
    endfunction

    assign n_last_l = slew_step(i_target_left, r_last_l, i_max_step);
    assign n_last_r = slew_step(i_target_right, r_last_r, i_max_step);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_l    <= '0;
            r_last_r    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_en && i_valid) begin
                r_last_l <= n_last_l;
                r_last_r <= n_last_r;
            end
            if (i_en) begin
                r_out_valid <= i_valid;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid            = r_out_valid;
    assign o_out_data.left_speed  = r_last_l;
    assign o_out_data.right_speed = r_last_r;

endmodule

// ===== rtl/braitenberg_wheel_speed_slew.sv =====
// Wheel speed command from eight proximity samples. Each beat on the input channel
// yields one beat on the output channel, registered at each stage in turn; a new beat
// is taken every cycle, and the whole pipeline (eight multiply lanes, sum, clamp,
// slew) holds while the output beat waits. Speeds are in 1/256 rad/s. Each result is
// clamped to +/- speed_limit and moves at most max_step_change from the previous
// result, which starts at zero after reset. Configuration writes are taken every cycle.
module braitenberg_wheel_speed_slew
    import bws_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_bws_in               i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_bws_out              o_out_data,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic signed [OFFSET_W-1:0] r_offset_left;
    logic signed [OFFSET_W-1:0] r_offset_right;
    logic [LIMIT_W-1:0]         r_speed_limit;
    logic [LIMIT_W-1:0]         r_max_step;
    logic                       r_lane_valid;
    logic                       w_en;
    logic [PROX_W-1:0]          w_prox   [NUM_LANES];
    logic signed [TERM_W-1:0]   w_term_l [NUM_LANES];
    logic signed [TERM_W-1:0]   w_term_r [NUM_LANES];
    logic                       w_tgt_valid;
    logic signed [SPEED_W-1:0]  w_tgt_l;
    logic signed [SPEED_W-1:0]  w_tgt_r;

    assign w_en        = !o_out_valid || i_out_ready;
    assign o_in_ready  = w_en;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset_left  <= OFFSET_RESET;
            r_offset_right <= OFFSET_RESET;
            r_speed_limit  <= LIMIT_RESET;
            r_max_step     <= STEP_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_OFFSET_LEFT:     r_offset_left  <= i_cfg_data[OFFSET_W-1:0];
                CFG_OFFSET_RIGHT:    r_offset_right <= i_cfg_data[OFFSET_W-1:0];
                CFG_SPEED_LIMIT:     r_speed_limit  <= i_cfg_data[LIMIT_W-1:0];
                CFG_MAX_STEP_CHANGE: r_max_step     <= i_cfg_data[LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lane_valid <= 1'b0;
        end else if (w_en) begin
            r_lane_valid <= i_in_valid;
        end
    end

    assign w_prox[0] = i_in_data.prox_0;
    assign w_prox[1] = i_in_data.prox_1;
    assign w_prox[2] = i_in_data.prox_2;
    assign w_prox[3] = i_in_data.prox_3;
    assign w_prox[4] = i_in_data.prox_4;
    assign w_prox[5] = i_in_data.prox_5;
    assign w_prox[6] = i_in_data.prox_6;
    assign w_prox[7] = i_in_data.prox_7;

    for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
        bws_lane u_lane (
            .i_clk   (i_clk),
            .i_en    (w_en),
            .i_prox  (w_prox[g]),
            .i_wl    (W_LEFT[g]),
            .i_wr    (W_RIGHT[g]),
            .o_left  (w_term_l[g]),
            .o_right (w_term_r[g])
        );
    end

    bws_merge u_merge (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_en           (w_en),
        .i_valid        (r_lane_valid),
        .i_left         (w_term_l),
        .i_right        (w_term_r),
        .i_offset_left  (r_offset_left),
        .i_offset_right (r_offset_right),
        .i_speed_limit  (r_speed_limit),
        .o_valid        (w_tgt_valid),
        .o_target_left  (w_tgt_l),
        .o_target_right (w_tgt_r)
    );

    bws_slew u_slew (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_en           (w_en),
        .i_valid        (w_tgt_valid),
        .i_target_left  (w_tgt_l),
        .i_target_right (w_tgt_r),
        .i_max_step     (r_max_step),
        .i_out_ready    (i_out_ready),
        .o_out_valid    (o_out_valid),
        .o_out_data     (o_out_data)
    );

endmodule

// ===== rtl/bws_checker.sv =====
`include "assert_macros.svh"

module bws_checker
    import bws_pkg::*;
(
    input logic     i_clk,
    input logic     i_rst_n,
    input logic     o_in_ready,
    input logic     o_out_valid,
    input logic     i_out_ready,
    input t_bws_out o_out_data
);

    `BWS_ASSERT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
    `BWS_ASSERT(a_ready_when_empty, i_clk, i_rst_n, !o_out_valid |-> o_in_ready)
    `BWS_ASSERT(a_stall_blocks_input, i_clk, i_rst_n, o_out_valid && !i_out_ready |-> !o_in_ready)
    `BWS_ASSERT_ALWAYS(a_reset_clears, i_clk, !i_rst_n |=> !o_out_valid)

endmodule

bind braitenberg_wheel_speed_slew bws_checker u_bws_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);
